FILE: rtl/core/pgbs_pkg.sv
// Package for the point grid binning block: types, constants, opcodes.
// Used by the divider and the top level in rtl/core.
package pgbs_pkg;
   localparam int NUM_ROWS_DEF   = 64;
   localparam int NUM_COLS_DEF   = 128;
   localparam int COORD_BITS     = 20;
   localparam int DIFF_BITS      = COORD_BITS + 1;
   localparam int QUOT_BITS      = COORD_BITS + 1;
   localparam int SUM_BITS       = 37;
   localparam int CNT_BITS       = 16;

   localparam logic [15:0] RST_COL_WIDTH  = 16'd102;
   localparam logic [19:0] RST_LAT_ORIGIN = 20'd0;
   localparam logic [18:0] RST_MAX_RANGE  = 19'd307200;
   localparam logic [6:0]  RST_ROWS_USE   = 7'd64;
   localparam logic [7:0]  RST_COLS_USE   = 8'd128;

   typedef enum logic [1:0] {
      OP_WRITE_BOUND = 2'd0,
      OP_ADD_POINT   = 2'd1,
      OP_READ_CELL   = 2'd2,
      OP_CLEAR_CELL  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_RANGE     = 2'd1,
      ST_OUTSIDE   = 2'd2,
      ST_SATURATED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CFG_COL_WIDTH  = 3'd0,
      CFG_LAT_ORIGIN = 3'd1,
      CFG_MAX_RANGE  = 3'd2,
      CFG_ROWS_USE   = 3'd3,
      CFG_COLS_USE   = 3'd4
   } cfg_index_type;

   typedef enum logic [3:0] {
      S_IDLE, S_CLEAR, S_SEARCH, S_DIVIDE, S_CHECK, S_READ, S_WAIT, S_UPDATE, S_OUT
   } state_type;

   // divider control
   typedef struct packed {
      logic                 start;
      logic [DIFF_BITS-1:0] dividend;
      logic [15:0]          divisor;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [QUOT_BITS-1:0] quotient;
   } div_rsp_type;
endpackage

FILE: rtl/core/pgbs_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on pgbs_pkg.
module pgbs_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  pgbs_pkg::div_req_type req,
   output pgbs_pkg::div_rsp_type rsp
);
   localparam int N = pgbs_pkg::DIFF_BITS;
   localparam int CW = $clog2(N + 1);

   logic [N-1:0]  quot_ff, quot_in;
   logic [16:0]   rem_ff, rem_in;
   logic [15:0]   dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [16:0]   trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[15:0], quot_ff[N-1]};
      if (req.start) begin
         quot_in = req.dividend;
         rem_in  = '0;
         dsr_in  = req.divisor;
         cnt_in  = CW'(N);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if ({rem_ff[15:0], quot_ff[N-1]} >= {1'b0, dsr_ff} || rem_ff[16] ||
             rem_ff[15]) begin
            rem_in = {rem_ff[15:0], quot_ff[N-1]} - {1'b0, dsr_ff};
            quot_in = {quot_ff[N-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quot_in = {quot_ff[N-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quot_ff;
endmodule

FILE: rtl/core/pgbs_cell_store.sv
// Cell statistics memory, one read and one write port, registered read.
module pgbs_cell_store #(
   parameter int DEPTH = 8192,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule

FILE: rtl/core/point_grid_binning_stats_top.sv
// Point grid binning block: top level with sequencer, boundary table and cell store.
// Depends on pgbs_pkg, pgbs_divider, pgbs_cell_store.
//
// One request beat in, one response beat out. After reset a clearing pass over all
// NUM_ROWS*NUM_COLS cells (8192 by default) zeroes the cell store; no request is
// taken meanwhile. An add-point beat runs a row search that reads one boundary per
// cycle, then the divider produces one column bit per cycle, then a read-modify-write
// of the cell. Read and clear also pass through the cell read; a boundary write or a
// point beyond range goes straight to the response. The response register holds
// until taken; the next request waits for it.
module point_grid_binning_stats_top #(
   parameter int NUM_ROWS = pgbs_pkg::NUM_ROWS_DEF,
   parameter int NUM_COLS = pgbs_pkg::NUM_COLS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_index,
   input  logic [19:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: coord_x[19:0], coord_y[39:20], coord_z[59:40], row_sel[65:60],
   // col_sel[72:66], zero pad to 80
   input  logic [79:0]  req_tdata,
   // tuser: opcode[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: cell_row[5:0], cell_col[12:6], point_count[28:13], low_x[48:29],
   // high_x[68:49], low_y[88:69], high_y[108:89], low_z[128:109], high_z[148:129],
   // total_x_out[185:149], total_z_out[222:186], zero pad to 224
   output logic [223:0] rsp_tdata,
   // tuser: status[1:0]
   output logic [1:0]   rsp_tuser
);
   localparam int COORD_BITS = pgbs_pkg::COORD_BITS;
   localparam int QB    = pgbs_pkg::QUOT_BITS;
   localparam int CELLS = NUM_ROWS * NUM_COLS;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
   localparam int CLW   = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;
   localparam int SB    = pgbs_pkg::SUM_BITS;
   localparam int CB    = pgbs_pkg::CNT_BITS;
   localparam int CEL_W = CB + 6 * COORD_BITS + 2 * SB;

   // configuration
   logic [15:0] col_width_ff;
   logic signed [19:0] lat_origin_ff;
   logic [18:0] max_range_ff;
   logic [6:0]  rows_use_ff;
   logic [7:0]  cols_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_width_ff  <= pgbs_pkg::RST_COL_WIDTH;
         lat_origin_ff <= pgbs_pkg::RST_LAT_ORIGIN;
         max_range_ff  <= pgbs_pkg::RST_MAX_RANGE;
         rows_use_ff   <= pgbs_pkg::RST_ROWS_USE;
         cols_use_ff   <= pgbs_pkg::RST_COLS_USE;
      end else if (csr_wr_en) begin
         case (pgbs_pkg::cfg_index_type'(csr_index))
            pgbs_pkg::CFG_COL_WIDTH:  col_width_ff  <= csr_wdata[15:0];
            pgbs_pkg::CFG_LAT_ORIGIN: lat_origin_ff <= csr_wdata;
            pgbs_pkg::CFG_MAX_RANGE:  max_range_ff  <= csr_wdata[18:0];
            pgbs_pkg::CFG_ROWS_USE:   rows_use_ff   <= csr_wdata[6:0];
            pgbs_pkg::CFG_COLS_USE:   cols_use_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // request fields
   logic signed [COORD_BITS-1:0] in_x, in_y, in_z;
   assign in_x = COORD_BITS'(signed'(req_tdata[19:0]));
   assign in_y = COORD_BITS'(signed'(req_tdata[39:20]));
   assign in_z = COORD_BITS'(signed'(req_tdata[59:40]));

   pgbs_pkg::state_type state_ff, state_in;
   pgbs_pkg::opcode_type op_ff, op_in;
   logic signed [COORD_BITS-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [5:0] rs_ff, rs_in;
   logic [6:0] cs_ff, cs_in;
   logic [8:0] j_ff, j_in;
   logic [RW-1:0] row_ff, row_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [1:0] wait_ff, wait_in;
   logic signed [COORD_BITS-1:0] prev_ff, prev_in;

   // boundary table (undefined until written)
   logic signed [COORD_BITS-1:0] bound_mem_ff [NUM_ROWS];
   logic signed [COORD_BITS-1:0] bound_rd_ff;
   logic        bound_we;
   logic [RW-1:0] bound_ra;
   always_ff @(posedge clock) begin
      if (bound_we) bound_mem_ff[RW'(rs_ff)] <= z_ff;
      bound_rd_ff <= bound_mem_ff[bound_ra];
   end

   // divider
   pgbs_pkg::div_req_type dreq;
   pgbs_pkg::div_rsp_type drsp;
   pgbs_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // cell store
   logic             cw_en;
   logic [AW-1:0]    cw_addr, c_addr_ff, c_addr_in;
   logic [CEL_W-1:0] cw_data, cr_data;
   pgbs_cell_store #(.DEPTH(CELLS), .WIDTH(CEL_W)) u_cells (
      .clock(clock), .wr_en(cw_en), .wr_addr(cw_addr), .wr_data(cw_data),
      .rd_addr(c_addr_ff), .rd_data(cr_data));

   // unpack of the read cell
   logic [CB-1:0] r_cnt;
   logic signed [COORD_BITS-1:0] r_lx, r_hx, r_ly, r_hy, r_lz, r_hz;
   logic signed [SB-1:0] r_sx, r_sz;
   assign {r_cnt, r_lx, r_hx, r_ly, r_hy, r_lz, r_hz, r_sx, r_sz} = cr_data;

   logic [CEL_W-1:0] cell_ff, cell_in;
   logic [1:0]       st_ff, st_in;
   logic             has_cell_ff, has_cell_in;
   logic [5:0]       o_row_ff, o_row_in;
   logic [6:0]       o_col_ff, o_col_in;
   logic             rv_ff, rv_in;

   logic [6:0] nrows;
   logic [8:0] ncols;
   logic signed [COORD_BITS:0] diff;
   logic hit;
   logic first;

   always_comb begin
      nrows = (int'(rows_use_ff) > NUM_ROWS) ? 7'(NUM_ROWS) : rows_use_ff;
      ncols = (int'(cols_use_ff) > NUM_COLS) ? 9'(NUM_COLS) : {1'b0, cols_use_ff};
      diff  = (COORD_BITS+1)'(y_ff) - (COORD_BITS+1)'(lat_origin_ff);
      if (j_ff == 9'd1) hit = (z_ff >= 0) && (z_ff <= bound_rd_ff);
      else              hit = (z_ff > prev_ff) && (z_ff <= bound_rd_ff);
      first = (r_cnt == '0);

      state_in = state_ff; op_in = op_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff; rs_in = rs_ff; cs_in = cs_ff;
      j_in = j_ff; row_in = row_ff; clr_in = clr_ff; wait_in = wait_ff;
      prev_in = prev_ff; c_addr_in = c_addr_ff;
      cell_in = cell_ff; st_in = st_ff; has_cell_in = has_cell_ff;
      o_row_in = o_row_ff; o_col_in = o_col_ff; rv_in = rv_ff;
      bound_we = 1'b0; bound_ra = j_ff[RW-1:0];
      cw_en = 1'b0; cw_addr = c_addr_ff; cw_data = '0;
      dreq.start = 1'b0;
      dreq.dividend = diff[pgbs_pkg::DIFF_BITS-1:0];
      dreq.divisor = col_width_ff;
      req_tready = (state_ff == pgbs_pkg::S_IDLE) && !rv_ff;

      if (rv_ff && rsp_tready) rv_in = 1'b0;

      case (state_ff)
         pgbs_pkg::S_CLEAR: begin
            cw_en = 1'b1; cw_addr = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(CELLS - 1)) state_in = pgbs_pkg::S_IDLE;
         end
         pgbs_pkg::S_IDLE: begin
            if (req_tvalid && req_tready) begin
               op_in = pgbs_pkg::opcode_type'(req_tuser);
               x_in = in_x; y_in = in_y; z_in = in_z;
               rs_in = req_tdata[65:60]; cs_in = req_tdata[72:66];
               has_cell_in = 1'b0; cell_in = '0;
               j_in = '0; row_in = '0;
               case (pgbs_pkg::opcode_type'(req_tuser))
                  pgbs_pkg::OP_ADD_POINT: state_in = pgbs_pkg::S_SEARCH;
                  default: state_in = pgbs_pkg::S_CHECK;
               endcase
            end
         end
         pgbs_pkg::S_SEARCH: begin
            // j_ff counts boundaries issued; data of entry j_ff-1 is in bound_rd_ff
            if (z_ff > $signed({1'b0, max_range_ff})) begin
               st_in = pgbs_pkg::ST_RANGE; o_row_in = '0; o_col_in = '0;
               state_in = pgbs_pkg::S_OUT;
            end else if (j_ff != 0 && hit) begin
               row_in = RW'(j_ff - 9'd1);
               dreq.start = 1'b1; state_in = pgbs_pkg::S_DIVIDE;
            end else if (j_ff >= {2'b0, nrows}) begin
               row_in = '0;
               dreq.start = 1'b1; state_in = pgbs_pkg::S_DIVIDE;
            end else begin
               bound_ra = j_ff[RW-1:0];
               j_in = j_ff + 1'b1;
            end
            if (j_ff != 0) prev_in = bound_rd_ff;
         end
         pgbs_pkg::S_DIVIDE: begin
            if (drsp.done) begin
               o_row_in = 6'(row_ff);
               o_col_in = 7'(drsp.quotient);
               if (diff < 0 || col_width_ff == '0 ||
                   drsp.quotient >= QB'(ncols)) begin
                  st_in = pgbs_pkg::ST_OUTSIDE; o_col_in = '0;
                  state_in = pgbs_pkg::S_OUT;
               end else begin
                  c_addr_in = AW'(row_ff * NUM_COLS +
                                  int'(drsp.quotient[CLW-1:0]));
                  wait_in = 2'd2; state_in = pgbs_pkg::S_READ;
               end
            end
         end
         pgbs_pkg::S_CHECK: begin
            o_row_in = rs_ff; o_col_in = cs_ff; st_in = pgbs_pkg::ST_OK;
            if (op_ff == pgbs_pkg::OP_WRITE_BOUND) begin
               o_col_in = '0;
               if (int'(rs_ff) >= NUM_ROWS) st_in = pgbs_pkg::ST_OUTSIDE;
               else bound_we = 1'b1;
               state_in = pgbs_pkg::S_OUT;
            end else if (int'(rs_ff) >= NUM_ROWS || int'(cs_ff) >= NUM_COLS) begin
               st_in = pgbs_pkg::ST_OUTSIDE; state_in = pgbs_pkg::S_OUT;
            end else begin
               c_addr_in = AW'(int'(rs_ff) * NUM_COLS + int'(cs_ff));
               wait_in = 2'd2; state_in = pgbs_pkg::S_READ;
            end
         end
         pgbs_pkg::S_READ: begin
            // address registered, then memory read register
            wait_in = wait_ff - 1'b1;
            if (wait_ff == 2'd1) state_in = pgbs_pkg::S_UPDATE;
         end
         pgbs_pkg::S_UPDATE: begin
            has_cell_in = 1'b1;
            state_in = pgbs_pkg::S_OUT;
            cell_in = cr_data;
            if (op_ff == pgbs_pkg::OP_CLEAR_CELL) begin
               cell_in = '0; cw_en = 1'b1; cw_data = '0;
            end else if (op_ff == pgbs_pkg::OP_ADD_POINT) begin
               if (r_cnt == '1) st_in = pgbs_pkg::ST_SATURATED;
               else begin
                  st_in = pgbs_pkg::ST_OK;
                  cell_in = {r_cnt + 1'b1,
                     (first || x_ff < r_lx) ? x_ff : r_lx,
                     (first || x_ff > r_hx) ? x_ff : r_hx,
                     (first || y_ff < r_ly) ? y_ff : r_ly,
                     (first || y_ff > r_hy) ? y_ff : r_hy,
                     (first || z_ff < r_lz) ? z_ff : r_lz,
                     (first || z_ff > r_hz) ? z_ff : r_hz,
                     r_sx + SB'(x_ff), r_sz + SB'(z_ff)};
                  cw_en = 1'b1; cw_data = cell_in;
               end
            end
         end
         pgbs_pkg::S_OUT: begin
            rv_in = 1'b1; state_in = pgbs_pkg::S_IDLE;
         end
         pgbs_pkg::S_WAIT: state_in = pgbs_pkg::S_IDLE;
         default: state_in = pgbs_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pgbs_pkg::S_CLEAR;
         clr_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rv_ff    <= rv_in;
      end
      op_ff <= op_in; x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
      rs_ff <= rs_in; cs_ff <= cs_in; j_ff <= j_in; row_ff <= row_in;
      wait_ff <= wait_in; prev_ff <= prev_in; c_addr_ff <= c_addr_in;
      cell_ff <= cell_in; st_ff <= st_in; has_cell_ff <= has_cell_in;
      o_row_ff <= o_row_in; o_col_ff <= o_col_in;
   end

   // response
   logic [CB-1:0] o_cnt;
   logic signed [COORD_BITS-1:0] o_lx, o_hx, o_ly, o_hy, o_lz, o_hz;
   logic signed [SB-1:0] o_sx, o_sz;
   assign {o_cnt, o_lx, o_hx, o_ly, o_hy, o_lz, o_hz, o_sx, o_sz} =
      has_cell_ff ? cell_ff : '0;

   assign rsp_tvalid = rv_ff;
   assign rsp_tuser  = st_ff;
   assign rsp_tdata  = {1'b0, o_sz, o_sx, 20'(o_hz), 20'(o_lz), 20'(o_hy), 20'(o_ly),
                        20'(o_hx), 20'(o_lx), o_cnt, o_col_ff, o_row_ff};

   // checks
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != pgbs_pkg::S_IDLE) |-> !req_tready)
      else $error("request taken while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !rsp_tready) |=> rv_ff && $stable(rsp_tdata))
      else $error("response dropped while stalled");
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      drsp.done |-> (state_ff == pgbs_pkg::S_DIVIDE))
      else $error("divider finished outside divide step");
endmodule

FILE: dv/point_grid_binning_stats_top_tb.sv
// Testbench for point_grid_binning_stats_top: random and directed opcode beats checked
// against an in-bench model of the grid binning. Depends on pgbs_pkg and the RTL only.
`timescale 1ns / 100ps

module point_grid_binning_stats_top_tb;
   localparam int ROWS  = 64;
   localparam int COLS  = 128;
   localparam int NCELL = ROWS * COLS;

   typedef struct packed {
      pgbs_pkg::opcode_type op;
      logic signed [19:0] x;
      logic signed [19:0] y;
      logic signed [19:0] z;
      logic [5:0]       rsel;
      logic [6:0]       csel;
   } req_beat_type;

   // field order follows the response beat, status on top, row in the lowest bits
   typedef struct packed {
      pgbs_pkg::status_type st;
      logic signed [36:0] sz, sx;
      logic signed [19:0] hz, lz, hy, ly, hx, lx;
      logic [15:0]        cnt;
      logic [6:0]         col;
      logic [5:0]         row;
   } cell_report_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_wr_en = 1'b0;
   logic [2:0]   csr_index = '0;
   logic [19:0]  csr_wdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [79:0]  req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [223:0] rsp_tdata;
   logic [1:0]   rsp_tuser;

   point_grid_binning_stats_top i_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // model state
   logic signed [19:0] bounds [ROWS];
   logic [15:0]        cnt_m  [NCELL];
   logic signed [19:0] lx_m [NCELL], hx_m [NCELL], ly_m [NCELL], hy_m [NCELL];
   logic signed [19:0] lz_m [NCELL], hz_m [NCELL];
   logic signed [36:0] sx_m [NCELL], sz_m [NCELL];
   int unsigned col_width = 102;
   int          lat_origin = 0;
   int unsigned max_range = 307200;
   int unsigned rows_use = 64;
   int unsigned cols_use = 128;

   req_beat_type    pending_beats [$];
   cell_report_type expected_reports [$];
   int  errors = 0;
   bit  hold_rsp = 1'b0;
   int  inflight = 0;

   function automatic cell_report_type report_cell(pgbs_pkg::status_type st, int row,
                                                   int col, int c);
      cell_report_type r;
      r = '0;
      r.st = st; r.row = 6'(row); r.col = 7'(col);
      if (c >= 0) begin
         r.cnt = cnt_m[c];
         r.lx = lx_m[c]; r.hx = hx_m[c]; r.ly = ly_m[c]; r.hy = hy_m[c];
         r.lz = lz_m[c]; r.hz = hz_m[c]; r.sx = sx_m[c]; r.sz = sz_m[c];
      end
      return r;
   endfunction

   function automatic void clear_cell(int c);
      cnt_m[c] = 0; lx_m[c] = 0; hx_m[c] = 0; ly_m[c] = 0; hy_m[c] = 0;
      lz_m[c] = 0; hz_m[c] = 0; sx_m[c] = 0; sz_m[c] = 0;
   endfunction

   function automatic cell_report_type bin_point(req_beat_type b);
      int nrows, row, c;
      longint diff, col;
      int z;
      z = b.z;
      if (b.op == pgbs_pkg::OP_WRITE_BOUND) begin
         bounds[b.rsel] = b.z;
         return report_cell(pgbs_pkg::ST_OK, b.rsel, 0, -1);
      end
      if (b.op == pgbs_pkg::OP_ADD_POINT) begin
         if (z > longint'(max_range)) return report_cell(pgbs_pkg::ST_RANGE, 0, 0, -1);
         nrows = rows_use < ROWS ? rows_use : ROWS;
         row = 0;
         for (int j = 0; j < nrows; j++) begin
            if (j == 0 ? (z >= 0 && z <= bounds[0]) : (z > bounds[j-1] && z <= bounds[j])) begin
               row = j;
               break;
            end
         end
         diff = longint'(b.y) - lat_origin;
         if (diff < 0 || col_width == 0) return report_cell(pgbs_pkg::ST_OUTSIDE, row, 0, -1);
         col = diff / col_width;
         if (col >= (cols_use < COLS ? cols_use : COLS))
            return report_cell(pgbs_pkg::ST_OUTSIDE, row, 0, -1);
         c = row * COLS + int'(col);
         if (cnt_m[c] == 16'hFFFF)
            return report_cell(pgbs_pkg::ST_SATURATED, row, int'(col), c);
         if (cnt_m[c] == 0) begin
            lx_m[c] = b.x; hx_m[c] = b.x; ly_m[c] = b.y; hy_m[c] = b.y;
            lz_m[c] = b.z; hz_m[c] = b.z;
         end else begin
            if (b.x < lx_m[c]) lx_m[c] = b.x;
            if (b.x > hx_m[c]) hx_m[c] = b.x;
            if (b.y < ly_m[c]) ly_m[c] = b.y;
            if (b.y > hy_m[c]) hy_m[c] = b.y;
            if (b.z < lz_m[c]) lz_m[c] = b.z;
            if (b.z > hz_m[c]) hz_m[c] = b.z;
         end
         sx_m[c] = sx_m[c] + b.x;
         sz_m[c] = sz_m[c] + b.z;
         cnt_m[c] = cnt_m[c] + 1;
         return report_cell(pgbs_pkg::ST_OK, row, int'(col), c);
      end
      c = b.rsel * COLS + b.csel;
      if (b.op == pgbs_pkg::OP_CLEAR_CELL) clear_cell(c);
      return report_cell(pgbs_pkg::ST_OK, b.rsel, b.csel, c);
   endfunction

   // driver
   int        req_gap = 0;
   req_beat_type cur;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_tready) begin
      end else begin
         if (req_tvalid) begin
            expected_reports.insert(expected_reports.size(), bin_point(cur));
            inflight--;
         end
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            cur = pending_beats.pop_front();
            req_tdata <= {7'd0, cur.csel, cur.rsel, cur.z, cur.y, cur.x};
            req_tuser <= cur.op;
            req_tvalid <= 1'b1;
            req_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   int           rsp_gap = 0;
   cell_report_type got, exp_r;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = cell_report_type'({rsp_tuser, rsp_tdata[222:0]});
            if (expected_reports.size() == 0) begin
               $display("%0t: unexpected beat %h", $time, got);
               errors++;
            end else begin
               exp_r = expected_reports.pop_front();
               if (got !== exp_r) begin
                  $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
                  errors++;
               end
            end
            rsp_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
         end
         if (hold_rsp) rsp_tready <= 1'b0;
         else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else rsp_tready <= 1'b1;
      end
   end

   // long receiver hold-off, counted here
   initial begin
      int n;
      n = 0;
      wait (!reset);
      repeat (9000) @(posedge clock);
      hold_rsp = 1'b1;
      while (n < 400) begin
         @(posedge clock);
         n++;
      end
      hold_rsp = 1'b0;
   end

   task automatic send(pgbs_pkg::opcode_type op, int x, int y, int z, int rs, int cs);
      req_beat_type b;
      b.op = op; b.x = 20'(x); b.y = 20'(y); b.z = 20'(z);
      b.rsel = 6'(rs); b.csel = 7'(cs);
      pending_beats.insert(pending_beats.size(), b);
      inflight++;
   endtask

   task automatic drain();
      while (inflight > 0 || expected_reports.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_reg(pgbs_pkg::cfg_index_type idx, int val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[19:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         pgbs_pkg::CFG_COL_WIDTH:  col_width = val & 16'hFFFF;
         pgbs_pkg::CFG_LAT_ORIGIN: lat_origin = int'(signed'(val[19:0]));
         pgbs_pkg::CFG_MAX_RANGE:  max_range = val & 19'h7FFFF;
         pgbs_pkg::CFG_ROWS_USE:   rows_use = val & 7'h7F;
         pgbs_pkg::CFG_COLS_USE:   cols_use = val & 8'hFF;
         default: ;
      endcase
   endtask

   task automatic load_bounds(int step);
      for (int j = 0; j < ROWS; j++)
         send(pgbs_pkg::OP_WRITE_BOUND, 0, 0, (j + 1) * step, j, 0);
   endtask

   // random beats: points mostly inside the grid, sometimes anywhere, plus cell reads and clears
   task automatic random_beats(int n, int span_y, int span_z);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 9);
         if (k < 6)
            send(pgbs_pkg::OP_ADD_POINT, $urandom(), lat_origin + $urandom_range(0, span_y),
                 $urandom_range(0, span_z), $urandom(), $urandom());
         else if (k == 6)
            send(pgbs_pkg::OP_ADD_POINT, $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom());
         else if (k == 7)
            send(pgbs_pkg::OP_READ_CELL, $urandom(), $urandom(), $urandom(),
                 $urandom_range(0, 3), $urandom_range(0, 7));
         else if (k == 8)
            send(pgbs_pkg::OP_READ_CELL, 0, 0, 0, $urandom(), $urandom());
         else
            send(pgbs_pkg::OP_CLEAR_CELL, 0, 0, 0, $urandom_range(0, 3),
                 $urandom_range(0, 7));
      end
   endtask

   initial begin
      for (int c = 0; c < NCELL; c++) clear_cell(c);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: bounds, extremes, every opcode and the range and outside cases
      load_bounds(1000);
      send(pgbs_pkg::OP_ADD_POINT, -524288, 0, 0, 0, 0);
      send(pgbs_pkg::OP_ADD_POINT, 524287, 101, 1000, 0, 0);
      send(pgbs_pkg::OP_ADD_POINT, 5, 102, 1001, 0, 0);
      send(pgbs_pkg::OP_ADD_POINT, 5, 12000, 64000, 0, 0);
      send(pgbs_pkg::OP_ADD_POINT, 1, 5, -5, 0, 0);
      send(pgbs_pkg::OP_ADD_POINT, 1, 5, 524287, 0, 0);
      send(pgbs_pkg::OP_ADD_POINT, 1, -1, 5, 0, 0);
      send(pgbs_pkg::OP_ADD_POINT, 1, 524287, 5, 0, 0);
      send(pgbs_pkg::OP_ADD_POINT, 1, 128 * 102, 5, 0, 0);
      send(pgbs_pkg::OP_READ_CELL, 0, 0, 0, 0, 0);
      send(pgbs_pkg::OP_READ_CELL, 0, 0, 0, 63, 127);
      send(pgbs_pkg::OP_CLEAR_CELL, 0, 0, 0, 0, 0);
      send(pgbs_pkg::OP_READ_CELL, 0, 0, 0, 0, 0);
      send(pgbs_pkg::OP_READ_CELL, 0, 0, 0, 1, 1);
      random_beats(500, 12000, 70000);
      drain();

      // narrow grid, negative origin, tight range
      write_reg(pgbs_pkg::CFG_COL_WIDTH, 1);
      write_reg(pgbs_pkg::CFG_LAT_ORIGIN, -524288);
      write_reg(pgbs_pkg::CFG_MAX_RANGE, 0);
      write_reg(pgbs_pkg::CFG_ROWS_USE, 1);
      write_reg(pgbs_pkg::CFG_COLS_USE, 1);
      send(pgbs_pkg::OP_ADD_POINT, 3, -524288, 0, 0, 0);
      send(pgbs_pkg::OP_ADD_POINT, 3, -524287, 0, 0, 0);
      send(pgbs_pkg::OP_ADD_POINT, 3, -524288, 1, 0, 0);
      random_beats(200, 3, 2);
      drain();

      // wide columns, full range
      write_reg(pgbs_pkg::CFG_COL_WIDTH, 65535);
      write_reg(pgbs_pkg::CFG_LAT_ORIGIN, 524287);
      write_reg(pgbs_pkg::CFG_MAX_RANGE, 524287);
      write_reg(pgbs_pkg::CFG_ROWS_USE, 0);
      write_reg(pgbs_pkg::CFG_COLS_USE, 200);
      send(pgbs_pkg::OP_ADD_POINT, 7, 524287, 524287, 0, 0);
      send(pgbs_pkg::OP_ADD_POINT, 7, 0, 5, 0, 0);
      drain();
      write_reg(pgbs_pkg::CFG_LAT_ORIGIN, -524288);
      write_reg(pgbs_pkg::CFG_ROWS_USE, 127);
      load_bounds(8000);
      random_beats(400, 1048575, 524287);
      drain();

      // zero column width, then back to moderate settings
      write_reg(pgbs_pkg::CFG_COL_WIDTH, 0);
      send(pgbs_pkg::OP_ADD_POINT, 1, 100, 100, 0, 0);
      drain();
      write_reg(pgbs_pkg::CFG_COL_WIDTH, 300);
      write_reg(pgbs_pkg::CFG_LAT_ORIGIN, -1000);
      write_reg(pgbs_pkg::CFG_MAX_RANGE, 307200);
      write_reg(pgbs_pkg::CFG_ROWS_USE, 64);
      write_reg(pgbs_pkg::CFG_COLS_USE, 8);
      load_bounds(4000);
      random_beats(600, 3000, 40000);
      drain();
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
